// File: hw/rtl/dbeq_pkg.sv
// shared types, constants and event checks for the double-buffered event queue
// no dependencies; imported by dbeq_store, dbeq_ctrl, double_buffered_event_queue and the testbench
`default_nettype none

package dbeq_pkg;

    // built capacity of one bank and the widths that follow from the field list
    localparam int CAPACITY      = 256;
    localparam int PAYLOAD_BYTES = 16;
    localparam int IDX_W         = 8;
    localparam int CNT_W         = 9;
    localparam int ADDR_W        = IDX_W + 1;
    localparam int DEPTH         = 2 * CAPACITY;
    localparam int SIZE_W        = 5;

    localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAPACITY);

    // request codes carried in tuser
    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_PUBLISH = 2'd1,
        MODE_READ    = 2'd2,
        MODE_CONSUME = 2'd3
    } mode_t;

    // event kind codes
    localparam logic [2:0] KIND_HEAL           = 3'd0;
    localparam logic [2:0] KIND_STATUS_APPLIED = 3'd1;
    localparam logic [2:0] KIND_STATUS_EXPIRED = 3'd2;
    localparam logic [2:0] KIND_DEATH          = 3'd3;

    // one stored event
    typedef struct packed {
        logic [63:0] tick;
        logic [63:0] payload_hi;
        logic [63:0] payload_lo;
        logic [2:0]  kind;
    } entry_t;

    // memory request from the controller
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        entry_t            wdata;
    } mem_cmd_t;

    // everything of a result except the entry data
    typedef struct packed {
        logic             ok;
        logic             rd_hit;
        logic [IDX_W-1:0] ordinal;
        logic [CNT_W-1:0] read_count;
        logic [CNT_W-1:0] write_room;
    } result_t;

    // payload byte count that each kind must declare, zero for unknown kinds
    function automatic logic [SIZE_W-1:0] kind_size(input logic [2:0] kind);
        logic [SIZE_W-1:0] sz;
        case (kind)
            KIND_HEAL:           sz = SIZE_W'(8);
            KIND_STATUS_APPLIED: sz = SIZE_W'(16);
            KIND_STATUS_EXPIRED: sz = SIZE_W'(8);
            KIND_DEATH:          sz = SIZE_W'(8);
            default:             sz = '0;
        endcase
        return sz;
    endfunction

    // kind known, size matches, bytes past the size are zero
    function automatic logic event_ok(input logic [2:0] kind, input logic [SIZE_W-1:0] size,
                                      input logic [63:0] hi);
        logic [SIZE_W-1:0] need;
        logic              good;
        need = kind_size(kind);
        good = (need != '0) && (32'(need) <= PAYLOAD_BYTES) && (size == need);
        if (need == SIZE_W'(8) && hi != '0)
        begin
            good = 1'b0;
        end
        return good;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dbeq_store.sv
// entry memory of both banks: one port, registered read data
// depends on dbeq_pkg
`default_nettype none

module dbeq_store (
    input  wire logic             clk,
    input  wire dbeq_pkg::mem_cmd_t cmd,
    output dbeq_pkg::entry_t      rdata
);
    import dbeq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/dbeq_ctrl.sv
// bank control: counts, bank select, capacity register, event checks and memory requests
// depends on dbeq_pkg
`default_nettype none

module dbeq_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [1:0]             mode,
    input  wire logic [63:0]            tick,
    input  wire logic [2:0]             ev_kind,
    input  wire logic [4:0]             decl_size,
    input  wire logic [63:0]            payload_lo,
    input  wire logic [63:0]            payload_hi,
    input  wire logic [7:0]             entry_index,
    input  wire logic                   cfg_wr_en,
    input  wire logic [8:0]             cfg_wr_data,
    output dbeq_pkg::mem_cmd_t          cmd,
    output dbeq_pkg::result_t           res
);
    import dbeq_pkg::*;

    logic [CNT_W-1:0] cap_reg, cap_next;
    logic             rbs_reg, rbs_next;
    logic [CNT_W-1:0] count_reg [2];
    logic [CNT_W-1:0] count_next [2];

    logic             wb;
    logic [CNT_W-1:0] c_w;
    logic [CNT_W-1:0] c_r;
    logic [CNT_W-1:0] c_wn;

    // capacity write, clipped to the built size
    assign cap_next = (cfg_wr_data > CAP_MAX) ? CAP_MAX : cfg_wr_data;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_MAX;
            rbs_reg      <= 1'b0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cap_next;
            end
            rbs_reg      <= rbs_next;
            count_reg[0] <= count_next[0];
            count_reg[1] <= count_next[1];
        end
    end

    assign wb  = ~rbs_reg;
    assign c_w = count_reg[wb];
    assign c_r = count_reg[rbs_reg];

    // request decode and count update
    always_comb
    begin
        count_next[0]    = count_reg[0];
        count_next[1]    = count_reg[1];
        rbs_next         = rbs_reg;
        cmd.wr_en        = 1'b0;
        cmd.rd_en        = 1'b0;
        cmd.addr         = '0;
        cmd.wdata.tick       = tick;
        cmd.wdata.payload_hi = payload_hi;
        cmd.wdata.payload_lo = payload_lo;
        cmd.wdata.kind       = ev_kind;
        res.ok           = 1'b0;
        res.rd_hit       = 1'b0;
        res.ordinal      = '0;
        if (accept)
        begin
            case (mode_t'(mode))
                MODE_APPEND:
                begin
                    if (event_ok(ev_kind, decl_size, payload_hi) &&
                        (c_w < cap_reg) && (c_w < CAP_MAX))
                    begin
                        cmd.wr_en      = 1'b1;
                        cmd.addr       = {wb, c_w[IDX_W-1:0]};
                        count_next[wb] = c_w + CNT_W'(1);
                        res.ok         = 1'b1;
                        res.ordinal    = c_w[IDX_W-1:0];
                    end
                end
                MODE_PUBLISH:
                begin
                    if (c_r == '0)
                    begin
                        rbs_next            = wb;
                        count_next[rbs_reg] = '0;
                        res.ok              = 1'b1;
                    end
                end
                MODE_READ:
                begin
                    if ({1'b0, entry_index} < c_r)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.addr    = {rbs_reg, entry_index};
                        res.ok      = 1'b1;
                        res.rd_hit  = 1'b1;
                        res.ordinal = entry_index;
                    end
                end
                MODE_CONSUME:
                begin
                    count_next[rbs_reg] = '0;
                    res.ok              = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        // counts as they stand after the request
        c_wn           = count_next[~rbs_next];
        res.read_count = count_next[rbs_next];
        res.write_room = (cap_reg > c_wn) ? (cap_reg - c_wn) : '0;
    end

endmodule

`default_nettype wire

// File: hw/rtl/double_buffered_event_queue.sv
// Two-bank ping-pong event queue. Each request on the slave stream (append, publish, read
// entry, consume; code in s_axis_tuser) yields exactly one result transfer on the master
// stream, in order. At the accepting edge the request is decoded, its result goes to the
// pending register and the single-port entry memory is read into the registered read data;
// both move to the output register once it is empty or being taken. A new
// request can be accepted every cycle while results drain; the single memory port, used once
// per request, sets that figure. Counts, bank select and the capacity register (cfg_wr_en /
// cfg_wr_data, values above 256 clip to 256) live in flip-flops; entries are read only after
// they are written, so the memory needs no clearing after reset. Write the capacity only
// while no request is in flight.
// depends on dbeq_pkg, dbeq_ctrl, dbeq_store
`default_nettype none

module double_buffered_event_queue (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tick[63:0], kind[66:64], declared size[71:67], payload_lo[135:72],
    // payload_hi[199:136], entry_index[207:200]
    input  wire logic [207:0] s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // ok[0], tick_out[64:1], kind_out[67:65], payload_lo_out[131:68],
    // payload_hi_out[195:132], ordinal_out[203:196], read_count[212:204],
    // write_room[221:213], zero fill [223:222]
    output logic [223:0]      m_axis_tdata,
    // capacity register
    input  wire logic         cfg_wr_en,
    input  wire logic [8:0]   cfg_wr_data
);
    import dbeq_pkg::*;

    logic     in_xfer;
    mem_cmd_t cmd;
    result_t  res;
    entry_t   rdata;
    entry_t   ent;

    logic     pend_valid_reg;
    result_t  pend_reg;
    logic     pend_move;
    logic     out_valid_reg;
    logic [223:0] out_data_reg;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    dbeq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_xfer),
        .mode         (s_axis_tuser),
        .tick         (s_axis_tdata[63:0]),
        .ev_kind      (s_axis_tdata[66:64]),
        .decl_size    (s_axis_tdata[71:67]),
        .payload_lo   (s_axis_tdata[135:72]),
        .payload_hi   (s_axis_tdata[199:136]),
        .entry_index  (s_axis_tdata[207:200]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .res          (res)
    );

    dbeq_store u_store (
        .clk   (clk),
        .cmd   (cmd),
        .rdata (rdata)
    );

    // pending result waits for the memory read, then moves to the output register
    assign pend_move     = pend_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !pend_valid_reg || pend_move;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // entry fields only for a read that hit
    assign ent = pend_reg.rd_hit ? rdata : '0;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pend_reg <= res;
        end
        if (pend_move)
        begin
            out_data_reg <= {2'b00, pend_reg.write_room, pend_reg.read_count, pend_reg.ordinal,
                             ent.payload_hi, ent.payload_lo, ent.kind, ent.tick, pend_reg.ok};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // an accepted request always has a pending result in the next cycle
    a_accept_pends: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> pend_valid_reg)
        else $error("accepted request left no pending result");

    // a read that hit lies inside the read bank
    a_read_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && pend_reg.rd_hit) |->
            (pend_reg.ok && ({1'b0, pend_reg.ordinal} < pend_reg.read_count)))
        else $error("read hit outside the read bank");

    // counts never pass the built capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[212:204] <= CAP_MAX) &&
                           (m_axis_tdata[221:213] <= CAP_MAX)))
        else $error("bank count beyond capacity");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the two-bank ping-pong event queue: a directed table, then random
// append / publish / read / consume sequences with random stalls on both streams
// depends on dbeq_pkg and double_buffered_event_queue
`timescale 1ns / 100ps

module testbench;

    import dbeq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 600;
    localparam int NO_WRITE     = -1;

    // one request as it travels on the slave stream
    typedef struct packed {
        mode_t       mode;
        logic [63:0] tick;
        logic [2:0]  kind;
        logic [4:0]  size;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  index;
    } request_t;

    // one result as it travels on the master stream
    typedef struct packed {
        logic        ok;
        logic [63:0] tick;
        logic [2:0]  kind;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  ordinal;
        logic [8:0]  read_count;
        logic [8:0]  write_room;
    } outcome_t;

    // directed row: optional capacity write before it, optional hand-typed result
    typedef struct {
        request_t req;
        int       cap;
        bit       known;
        outcome_t want;
    } script_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [223:0] m_axis_tdata;
    logic         cfg_wr_en;
    logic [8:0]   cfg_wr_data;

    // shadow copy of the queue state
    logic        read_sel;
    int unsigned bank_fill [2];
    int unsigned cap_eff;
    logic [63:0] tick_mem [2*CAPACITY];
    logic [63:0] lo_mem   [2*CAPACITY];
    logic [63:0] hi_mem   [2*CAPACITY];
    logic [2:0]  kind_mem [2*CAPACITY];

    outcome_t    pending_results [$];
    script_row_t script [$];
    int          mismatches;
    int          requests_sent;
    int          cycle_count;
    bit          quiet;

    double_buffered_event_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // payload length each kind must declare, zero when the kind is unknown
    function automatic int unsigned payload_len(logic [2:0] kind);
        case (kind)
            KIND_HEAL:           return 8;
            KIND_STATUS_APPLIED: return 16;
            KIND_STATUS_EXPIRED: return 8;
            KIND_DEATH:          return 8;
            default:             return 0;
        endcase
    endfunction

    // apply one request to the shadow state and work out its result
    function automatic outcome_t predict_outcome(request_t r);
        outcome_t    o;
        logic        rb;
        logic        wb;
        int unsigned c;
        int unsigned slot;
        int unsigned need;
        o = '0;
        rb = read_sel;
        wb = ~read_sel;
        case (r.mode)
            MODE_APPEND:
            begin
                c = bank_fill[wb];
                need = payload_len(r.kind);
                if (need != 0 && r.size == need && !(need == 8 && r.hi != '0) && c < cap_eff)
                begin
                    slot = wb * CAPACITY + c;
                    tick_mem[slot] = r.tick;
                    lo_mem[slot] = r.lo;
                    hi_mem[slot] = r.hi;
                    kind_mem[slot] = r.kind;
                    bank_fill[wb] = c + 1;
                    o.ok = 1'b1;
                    o.ordinal = c[7:0];
                end
            end
            MODE_PUBLISH:
            begin
                if (bank_fill[rb] == 0)
                begin
                    read_sel = wb;
                    o.ok = 1'b1;
                end
            end
            MODE_READ:
            begin
                if (r.index < bank_fill[rb])
                begin
                    slot = rb * CAPACITY + r.index;
                    o.ok = 1'b1;
                    o.tick = tick_mem[slot];
                    o.kind = kind_mem[slot];
                    o.lo = lo_mem[slot];
                    o.hi = hi_mem[slot];
                    o.ordinal = r.index;
                end
            end
            default:
            begin
                bank_fill[rb] = 0;
                o.ok = 1'b1;
            end
        endcase
        c = bank_fill[~read_sel];
        o.read_count = 9'(bank_fill[read_sel]);
        o.write_room = cap_eff > c ? 9'(cap_eff - c) : '0;
        return o;
    endfunction

    function automatic request_t make_req(mode_t m, logic [63:0] t, logic [2:0] k,
                                          logic [4:0] sz, logic [63:0] lo, logic [63:0] hi,
                                          logic [7:0] ix);
        request_t r;
        r.mode = m;
        r.tick = t;
        r.kind = k;
        r.size = sz;
        r.lo = lo;
        r.hi = hi;
        r.index = ix;
        return r;
    endfunction

    function automatic void plan(request_t r, int cap, bit known, bit ok, logic [7:0] ord,
                                 logic [8:0] rc, logic [8:0] wr);
        script_row_t row;
        row.req = r;
        row.cap = cap;
        row.known = known;
        row.want = '0;
        row.want.ok = ok;
        row.want.ordinal = ord;
        row.want.read_count = rc;
        row.want.write_room = wr;
        script.push_back(row);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // a well-formed event with random content, or random noise in every field
    function automatic request_t random_append(bit well_formed);
        request_t r;
        r = make_req(MODE_APPEND, rand64(), 3'($urandom_range(0, 3)), '0, rand64(), '0,
                     8'($urandom));
        if (well_formed)
        begin
            r.size = 5'(payload_len(r.kind));
            if (r.kind == KIND_STATUS_APPLIED)
                r.hi = rand64();
        end
        else
        begin
            r.kind = 3'($urandom_range(0, 7));
            r.size = 5'($urandom_range(0, 31));
            r.hi = ($urandom_range(0, 1) == 1) ? rand64() : '0;
        end
        return r;
    endfunction

    function automatic request_t random_read();
        int unsigned top;
        top = bank_fill[read_sel] > 255 ? 255 : bank_fill[read_sel];
        if ($urandom_range(0, 4) == 0)
            top = 255;
        return make_req(MODE_READ, rand64(), 3'($urandom), 5'($urandom), rand64(), rand64(),
                        8'($urandom_range(0, top)));
    endfunction

    function automatic int unsigned pick_capacity();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 511;
            2:       return 256;
            3:       return $urandom_range(0, 511);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // hold the request stream, let every result drain, then write the capacity
    task automatic set_capacity(int unsigned value);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = 9'(value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cap_eff = value > CAPACITY ? CAPACITY : value;
    endtask

    // present one request after a random gap; enters and leaves on a falling edge
    task automatic send(request_t r, bit known, outcome_t want);
        int       gap;
        outcome_t predicted;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata = {r.index, r.hi, r.lo, r.size, r.kind, r.tick};
        s_axis_tuser = r.mode;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = predict_outcome(r);
        pending_results.push_back(known ? want : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    // result side: random stall before each transfer
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("ok", want.ok, m_axis_tdata[0]);
                check_field("tick_out", want.tick, m_axis_tdata[64:1]);
                check_field("kind_out", want.kind, m_axis_tdata[67:65]);
                check_field("payload_lo_out", want.lo, m_axis_tdata[131:68]);
                check_field("payload_hi_out", want.hi, m_axis_tdata[195:132]);
                check_field("ordinal_out", want.ordinal, m_axis_tdata[203:196]);
                check_field("read_count", want.read_count, m_axis_tdata[212:204]);
                check_field("write_room", want.write_room, m_axis_tdata[221:213]);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int       total;
        int       n;
        request_t r;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_APPEND;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        mismatches = 0;
        requests_sent = 0;
        cycle_count = 0;
        quiet = 1'b0;
        read_sel = 1'b0;
        bank_fill[0] = 0;
        bank_fill[1] = 0;
        cap_eff = CAPACITY;

        // directed table: reset state, field extremes, rejected events, full and shrunk banks
        plan(make_req(MODE_READ, '1, '1, '1, '1, '1, 8'd255), NO_WRITE, 1, 0, 0, 0, 256);
        plan(make_req(MODE_PUBLISH, '0, '0, '0, '0, '0, '0), NO_WRITE, 1, 1, 0, 0, 256);
        plan(make_req(MODE_CONSUME, '0, '0, '0, '0, '0, '0), NO_WRITE, 1, 1, 0, 0, 256);
        plan(make_req(MODE_APPEND, '1, KIND_HEAL, 5'd8, '1, '0, '0), NO_WRITE, 1, 1, 0, 0, 255);
        plan(make_req(MODE_APPEND, '0, KIND_STATUS_APPLIED, 5'd16, '0, '1, '1), NO_WRITE,
             1, 1, 1, 0, 254);
        // 8-byte kind with a stray high byte
        plan(make_req(MODE_APPEND, 64'h5, KIND_STATUS_EXPIRED, 5'd8, 64'h1,
                      64'h8000_0000_0000_0000, '0), NO_WRITE, 1, 0, 0, 0, 254);
        // declared size does not match the kind
        plan(make_req(MODE_APPEND, 64'h6, KIND_DEATH, 5'd16, 64'h2, '0, '0), NO_WRITE,
             1, 0, 0, 0, 254);
        plan(make_req(MODE_APPEND, '1, 3'd7, 5'd31, '1, '1, '1), NO_WRITE, 1, 0, 0, 0, 254);
        plan(make_req(MODE_APPEND, 64'h7, 3'd4, 5'd8, 64'h3, '0, '0), NO_WRITE, 1, 0, 0, 0, 254);
        plan(make_req(MODE_APPEND, 64'h8, KIND_STATUS_APPLIED, 5'd8, 64'h4, '0, '0), NO_WRITE,
             1, 0, 0, 0, 254);
        plan(make_req(MODE_APPEND, 64'h0123_4567_89ab_cdef, KIND_STATUS_EXPIRED, 5'd8,
                      64'hfedc_ba98_7654_3210, '0, '0), NO_WRITE, 0, 0, 0, 0, 0);
        plan(make_req(MODE_APPEND, 64'h2a, KIND_DEATH, 5'd8, 64'h5555_aaaa_5555_aaaa, '0, '0),
             NO_WRITE, 0, 0, 0, 0, 0);
        plan(make_req(MODE_PUBLISH, '0, '0, '0, '0, '0, '0), NO_WRITE, 0, 0, 0, 0, 0);
        // read bank still holds entries
        plan(make_req(MODE_PUBLISH, '0, '0, '0, '0, '0, '0), NO_WRITE, 1, 0, 0, 4, 256);
        plan(make_req(MODE_READ, '0, '0, '0, '0, '0, 8'd0), NO_WRITE, 0, 0, 0, 0, 0);
        plan(make_req(MODE_READ, '0, '0, '0, '0, '0, 8'd1), NO_WRITE, 0, 0, 0, 0, 0);
        plan(make_req(MODE_READ, '0, '0, '0, '0, '0, 8'd3), NO_WRITE, 0, 0, 0, 0, 0);
        plan(make_req(MODE_READ, '1, '1, '1, '1, '1, 8'd4), NO_WRITE, 1, 0, 0, 4, 256);
        plan(make_req(MODE_APPEND, 64'h10, KIND_HEAL, 5'd8, 64'h11, '0, '0), 2, 0, 0, 0, 0, 0);
        plan(make_req(MODE_APPEND, 64'h12, KIND_STATUS_APPLIED, 5'd16, 64'h13, 64'h14, '0),
             NO_WRITE, 0, 0, 0, 0, 0);
        // write bank full
        plan(make_req(MODE_APPEND, 64'h15, KIND_HEAL, 5'd8, 64'h16, '0, '0), NO_WRITE,
             1, 0, 0, 4, 0);
        // capacity lowered below the stored count
        plan(make_req(MODE_APPEND, 64'h17, KIND_DEATH, 5'd8, 64'h18, '0, '0), 1, 1, 0, 0, 4, 0);
        plan(make_req(MODE_CONSUME, '0, '0, '0, '0, '0, '0), 0, 1, 1, 0, 0, 0);
        plan(make_req(MODE_APPEND, 64'h19, KIND_HEAL, 5'd8, 64'h1a, '0, '0), NO_WRITE,
             1, 0, 0, 0, 0);
        // capacity above the built size clips
        plan(make_req(MODE_PUBLISH, '0, '0, '0, '0, '0, '0), 511, 1, 1, 0, 2, 256);
        plan(make_req(MODE_READ, '0, '0, '0, '0, '0, 8'd1), NO_WRITE, 0, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].cap != NO_WRITE)
                set_capacity(script[i].cap);
            send(script[i].req, script[i].known, script[i].want);
        end

        // random rounds: fill, read, consume, publish, read again, a little noise
        total = requests_sent + RANDOM_ITEMS;
        while (requests_sent < total)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                set_capacity(pick_capacity());
            n = $urandom_range(0, cap_eff < 16 ? cap_eff + 2 : 20);
            repeat (n) send(random_append($urandom_range(0, 6) != 0), 0, '0);
            repeat ($urandom_range(0, 4)) send(random_read(), 0, '0);
            if ($urandom_range(0, 4) != 0)
                send(make_req(MODE_CONSUME, rand64(), 3'($urandom), 5'($urandom), rand64(),
                              rand64(), 8'($urandom)), 0, '0);
            send(make_req(MODE_PUBLISH, rand64(), 3'($urandom), 5'($urandom), rand64(),
                          rand64(), 8'($urandom)), 0, '0);
            repeat ($urandom_range(0, 4)) send(random_read(), 0, '0);
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    r = make_req(mode_t'($urandom_range(0, 3)), rand64(), 3'($urandom),
                                 5'($urandom), rand64(), rand64(), 8'($urandom));
                    send(r, 0, '0);
                end
            end
        end

        // drain and allow for stray transfers
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dbeq_pkg.sv
hw/rtl/dbeq_store.sv
hw/rtl/dbeq_ctrl.sv
hw/rtl/double_buffered_event_queue.sv
bench/testbench.sv
